[rtl/core/mbx_pkg.sv]
// Shared types and constants for the per-port message mailbox.
// Used by the slot cells, the top level and the port checker; depends on nothing.

package mbx_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 3;
   // Widths sized for the largest supported table (256 slots of 256 words).
   localparam int SLOT_W    = 8;
   localparam int FILL_W    = 9;
   localparam int BASE_W    = 16;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED     = 3'd0,
      ST_DELIVERED  = 3'd1,
      ST_EMPTY      = 3'd2,
      ST_UNKNOWN    = 3'd3,
      ST_PORT_FULL  = 3'd4,
      ST_TABLE_FULL = 3'd5
   } status_type;

   // Search token that walks the chain of slot cells, one cell per cycle.
   typedef struct packed {
      logic              active;
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [FILL_W-1:0] fill;
      logic [BASE_W-1:0] base;
   } token_type;

   // Update broadcast from the top level to the slot cells.
   typedef struct packed {
      logic              en;
      logic              claim;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  key;
      logic [FILL_W-1:0] fill;
   } cell_update_type;

endpackage

[rtl/core/mbx_ram.sv]
// Generic single-port RAM with a registered read.
// Depends on nothing; holds the message stacks of the mailbox.

module mbx_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                           wr_data,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mbx_cell.sv]
// One slot of the port table: key, claimed flag and stack fill count.
// Depends on mbx_pkg; passes the registered search token to the next cell.

module mbx_cell #(
   parameter int INDEX        = 0,
   parameter int MAX_PER_PORT = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [mbx_pkg::KEY_W-1:0] cmd_key,
   input  mbx_pkg::token_type       tok_in,
   input  mbx_pkg::cell_update_type upd,
   output mbx_pkg::token_type       tok_out
);

   localparam int CW   = $clog2(MAX_PER_PORT + 1);
   localparam int BASE = INDEX * MAX_PER_PORT;

   logic                      used_ff;
   logic                      used_in;
   logic [mbx_pkg::KEY_W-1:0] key_ff;
   logic [mbx_pkg::KEY_W-1:0] key_in;
   logic [CW-1:0]             fill_ff;
   logic [CW-1:0]             fill_in;
   mbx_pkg::token_type        tok_ff;
   mbx_pkg::token_type        tok_in_next;
   logic                      sel;

   assign sel = upd.en && (upd.slot == mbx_pkg::SLOT_W'(INDEX));

   always_comb begin
      used_in     = used_ff;
      key_in      = key_ff;
      fill_in     = fill_ff;
      tok_in_next = tok_in;
      if (sel) begin
         if (upd.claim) begin
            used_in = 1'b1;
            key_in  = upd.key;
         end
         fill_in = upd.fill[CW-1:0];
      end
      // The first claimed slot whose key matches takes the token.
      if (tok_in.active && !tok_in.found && used_ff && (key_ff == cmd_key)) begin
         tok_in_next.found = 1'b1;
         tok_in_next.slot  = mbx_pkg::SLOT_W'(INDEX);
         tok_in_next.fill  = mbx_pkg::FILL_W'(fill_ff);
         tok_in_next.base  = mbx_pkg::BASE_W'(BASE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff        <= 1'b0;
         fill_ff        <= '0;
         tok_ff.active  <= 1'b0;
      end else begin
         used_ff <= used_in;
         fill_ff <= fill_in;
         tok_ff  <= tok_in_next;
      end
      key_ff <= key_in;
   end

   assign tok_out = tok_ff;

endmodule

[rtl/core/per_port_message_mailbox.sv]
// Top level of the per-port message mailbox: command port, slot cell chain, stack RAM.
// Depends on mbx_pkg, mbx_cell and mbx_ram.
//
//   channel   | ports                                   | flow control
//   ----------+-----------------------------------------+--------------------------
//   command   | start, req_kind, req_port_id, req_payload | taken when start && !busy
//   response  | rsp_valid, rsp_status, rsp_reply_payload  | one-cycle strobe
//
// In a command, a search token walks the chain of slot cells one cell per cycle, then
// the cell and the stack RAM are updated as the command needs, and a delivered pop
// passes through the read state S_READ for the registered RAM read.
// The response beat appears in the first cycle that busy is low, so a new command
// may be taken alongside it. Reset empties the table at once; no clearing pass.
// The response side cannot stall; every beat is taken as it appears.

module per_port_message_mailbox #(
   parameter int MAX_PORTS    = 32,
   parameter int MAX_PER_PORT = 32,
   parameter int MESSAGE_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [mbx_pkg::KEY_W-1:0]     req_port_id,
   input  logic [mbx_pkg::PAYLOAD_W-1:0] req_payload,
   output logic                          rsp_valid,
   output logic [mbx_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mbx_pkg::PAYLOAD_W-1:0] rsp_reply_payload
);

   localparam int DEPTH = MAX_PORTS * MAX_PER_PORT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = $clog2(MAX_PORTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_READ
   } state_type;

   state_type                     state_ff, state_in;
   logic                          launch_ff, launch_in;
   logic                          cmd_kind_ff, cmd_kind_in;
   logic [mbx_pkg::KEY_W-1:0]     cmd_key_ff, cmd_key_in;
   logic [MESSAGE_BITS-1:0]       cmd_payload_ff, cmd_payload_in;
   logic [PW-1:0]                 ports_in_use_ff, ports_in_use_in;
   logic [AW-1:0]                 next_base_ff, next_base_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   mbx_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [mbx_pkg::PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;

   mbx_pkg::token_type            tok [MAX_PORTS+1];
   mbx_pkg::token_type            tok_last;
   mbx_pkg::cell_update_type      upd;
   logic                          ram_we;
   logic [AW-1:0]                 ram_addr;
   logic [MESSAGE_BITS-1:0]       ram_rdata;

   always_comb begin
      tok[0]        = '0;
      tok[0].active = launch_ff;
   end

   for (genvar i = 0; i < MAX_PORTS; i++) begin : g_cell
      mbx_cell #(
         .INDEX        (i),
         .MAX_PER_PORT (MAX_PER_PORT)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd_key (cmd_key_ff),
         .tok_in  (tok[i]),
         .upd     (upd),
         .tok_out (tok[i+1])
      );
   end

   assign tok_last = tok[MAX_PORTS];

   mbx_ram #(
      .WIDTH (MESSAGE_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (cmd_payload_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in        = state_ff;
      launch_in       = 1'b0;
      cmd_kind_in     = cmd_kind_ff;
      cmd_key_in      = cmd_key_ff;
      cmd_payload_in  = cmd_payload_ff;
      ports_in_use_in = ports_in_use_ff;
      next_base_in    = next_base_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_payload_in  = rsp_payload_ff;
      upd             = '0;
      ram_we          = 1'b0;
      ram_addr        = tok_last.base[AW-1:0] + AW'(tok_last.fill);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_kind_in    = req_kind;
               cmd_key_in     = req_port_id;
               cmd_payload_in = req_payload[MESSAGE_BITS-1:0];
               launch_in      = 1'b1;
               state_in       = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (tok_last.active) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '0;
               if (cmd_kind_ff) begin
                  if (!tok_last.found) begin
                     rsp_status_in = mbx_pkg::ST_UNKNOWN;
                  end else if (tok_last.fill == '0) begin
                     rsp_status_in = mbx_pkg::ST_EMPTY;
                  end else begin
                     // Pop: the word sits one below the fill count.
                     ram_addr     = tok_last.base[AW-1:0] + AW'(tok_last.fill) - AW'(1);
                     upd.en       = 1'b1;
                     upd.slot     = tok_last.slot;
                     upd.fill     = tok_last.fill - mbx_pkg::FILL_W'(1);
                     rsp_valid_in = 1'b0;
                     state_in     = S_READ;
                  end
               end else begin
                  if (!tok_last.found) begin
                     if (ports_in_use_ff == PW'(MAX_PORTS)) begin
                        rsp_status_in = mbx_pkg::ST_TABLE_FULL;
                     end else begin
                        ram_we          = 1'b1;
                        ram_addr        = next_base_ff;
                        upd.en          = 1'b1;
                        upd.claim       = 1'b1;
                        upd.slot        = mbx_pkg::SLOT_W'(ports_in_use_ff);
                        upd.key         = cmd_key_ff;
                        upd.fill        = mbx_pkg::FILL_W'(1);
                        ports_in_use_in = ports_in_use_ff + PW'(1);
                        next_base_in    = next_base_ff + AW'(MAX_PER_PORT);
                        rsp_status_in   = mbx_pkg::ST_STORED;
                     end
                  end else if (tok_last.fill == mbx_pkg::FILL_W'(MAX_PER_PORT)) begin
                     rsp_status_in = mbx_pkg::ST_PORT_FULL;
                  end else begin
                     ram_we        = 1'b1;
                     upd.en        = 1'b1;
                     upd.slot      = tok_last.slot;
                     upd.fill      = tok_last.fill + mbx_pkg::FILL_W'(1);
                     rsp_status_in = mbx_pkg::ST_STORED;
                  end
               end
            end
         end
         S_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = mbx_pkg::ST_DELIVERED;
            rsp_payload_in = mbx_pkg::PAYLOAD_W'(ram_rdata);
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         launch_ff       <= 1'b0;
         ports_in_use_ff <= '0;
         next_base_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         launch_ff       <= launch_in;
         ports_in_use_ff <= ports_in_use_in;
         next_base_ff    <= next_base_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_kind_ff    <= cmd_kind_in;
      cmd_key_ff     <= cmd_key_in;
      cmd_payload_ff <= cmd_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_reply_payload = rsp_payload_ff;

endmodule

[rtl/core/mbx_checker.sv]
// Port-level checks on the per-port message mailbox, bound to its top level.
// Depends on mbx_pkg for the status codes.

module mbx_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [mbx_pkg::STATUS_W-1:0]  rsp_status,
   input logic [mbx_pkg::PAYLOAD_W-1:0] rsp_reply_payload
);

   // An accepted command keeps the block busy in the next cycle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command accepted but block not busy");

   // A response beat is only shown once the command has finished.
   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while busy");

   // One beat per command; response beats are never back to back.
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response beats");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= mbx_pkg::ST_TABLE_FULL))
      else $error("response status out of range");

   a_payload_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != mbx_pkg::ST_DELIVERED)) |-> (rsp_reply_payload == '0))
      else $error("reply payload not zero on a non-delivery");

endmodule

bind per_port_message_mailbox mbx_checker u_mbx_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_reply_payload (rsp_reply_payload)
);

[bench/per_port_message_mailbox_tb.sv]
// Self-checking testbench for the per-port message mailbox: command beats go in through
// start/busy and every response beat is checked against a behavioural mailbox model.
// Depends on mbx_pkg and per_port_message_mailbox.
`timescale 1ns / 100ps

module per_port_message_mailbox_tb;

   localparam int NUM_PORTS   = 32;
   localparam int STACK_DEPTH = 32;
   localparam int WORD_BITS   = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [mbx_pkg::PAYLOAD_W-1:0] WORD_MASK =
      {mbx_pkg::PAYLOAD_W{1'b1}} >> (mbx_pkg::PAYLOAD_W - WORD_BITS);

   typedef struct packed {
      mbx_pkg::status_type           status;
      logic [mbx_pkg::PAYLOAD_W-1:0] word;
   } mailbox_reply_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_kind;
   logic [mbx_pkg::KEY_W-1:0]     req_port_id;
   logic [mbx_pkg::PAYLOAD_W-1:0] req_payload;
   logic                          rsp_valid;
   logic [mbx_pkg::STATUS_W-1:0]  rsp_status;
   logic [mbx_pkg::PAYLOAD_W-1:0] rsp_reply_payload;

   // Model of the mailbox contents.
   logic [mbx_pkg::KEY_W-1:0]     slot_key   [NUM_PORTS];
   int unsigned                   depth_of   [NUM_PORTS];
   logic [mbx_pkg::PAYLOAD_W-1:0] stack_word [NUM_PORTS][STACK_DEPTH];
   int unsigned                   slots_used;

   mailbox_reply_type pending_replies[$];
   int unsigned       error_count;
   int unsigned       cycle_count;
   bit                gaps_enabled;

   per_port_message_mailbox #(
      .MAX_PORTS    (NUM_PORTS),
      .MAX_PER_PORT (STACK_DEPTH),
      .MESSAGE_BITS (WORD_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_port_id       (req_port_id),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_reply_payload (rsp_reply_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic mailbox_reply_type mailbox_predict(
         input logic                          op,
         input logic [mbx_pkg::KEY_W-1:0]     id,
         input logic [mbx_pkg::PAYLOAD_W-1:0] word);
      mailbox_reply_type r;
      int unsigned       slot;
      int unsigned       s;
      slot   = NUM_PORTS;
      r.word = '0;
      for (s = 0; s < slots_used; s++) begin
         if (slot == NUM_PORTS && slot_key[s] == id) slot = s;
      end
      if (op) begin
         if (slot == NUM_PORTS) begin
            r.status = mbx_pkg::ST_UNKNOWN;
         end else if (depth_of[slot] == 0) begin
            r.status = mbx_pkg::ST_EMPTY;
         end else begin
            depth_of[slot]--;
            r.word   = stack_word[slot][depth_of[slot]];
            r.status = mbx_pkg::ST_DELIVERED;
         end
      end else if (slot == NUM_PORTS) begin
         if (slots_used == NUM_PORTS) begin
            r.status = mbx_pkg::ST_TABLE_FULL;
         end else begin
            slot_key[slots_used]      = id;
            stack_word[slots_used][0] = word & WORD_MASK;
            depth_of[slots_used]      = 1;
            slots_used++;
            r.status = mbx_pkg::ST_STORED;
         end
      end else if (depth_of[slot] == STACK_DEPTH) begin
         r.status = mbx_pkg::ST_PORT_FULL;
      end else begin
         stack_word[slot][depth_of[slot]] = word & WORD_MASK;
         depth_of[slot]++;
         r.status = mbx_pkg::ST_STORED;
      end
      return r;
   endfunction

   // Entered and left at a falling edge; start stays high between back-to-back beats.
   task automatic send_beat(input logic op, input logic [mbx_pkg::KEY_W-1:0] id,
                            input logic [mbx_pkg::PAYLOAD_W-1:0] word);
      int gap;
      if (gaps_enabled && $urandom_range(0, 99) < 26) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_kind    <= op;
      req_port_id <= id;
      req_payload <= word;
      do @(posedge clock); while (busy);
      pending_replies.push_back(mailbox_predict(op, id, word));
      @(negedge clock);
   endtask

   function automatic logic [mbx_pkg::PAYLOAD_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly ports that are already known, sometimes a fresh identifier.
   function automatic logic [mbx_pkg::KEY_W-1:0] pick_port_key();
      if (slots_used > 0 && $urandom_range(0, 99) < 80)
         return slot_key[$urandom_range(0, slots_used - 1)];
      return $urandom;
   endfunction

   always @(posedge clock) begin
      mailbox_reply_type exp;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected response beat, status %0d payload %h",
                     $time, rsp_status, rsp_reply_payload);
            error_count++;
         end else begin
            exp = pending_replies.pop_front();
            if (rsp_status !== exp.status) begin
               $display("%0t: status mismatch, expected %0d (%s) actual %0d",
                        $time, exp.status, exp.status.name(), rsp_status);
               error_count++;
            end
            if (rsp_reply_payload !== exp.word) begin
               $display("%0t: reply payload mismatch, expected %h actual %h",
                        $time, exp.word, rsp_reply_payload);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      send_beat(1'b1, 32'h0000_0000, '0);
      send_beat(1'b0, 32'h0000_0000, '0);
      send_beat(1'b0, 32'hFFFF_FFFF, '1);
      send_beat(1'b0, 32'hFFFF_FFFF, 64'hA5A5_5A5A_0F0F_F0F0);
      send_beat(1'b1, 32'hFFFF_FFFF, '1);
      send_beat(1'b1, 32'hFFFF_FFFF, '0);
      send_beat(1'b1, 32'hFFFF_FFFF, random_word());
      send_beat(1'b1, 32'h0000_0000, random_word());
      send_beat(1'b1, 32'h0000_0000, '0);
      send_beat(1'b1, 32'h8000_0001, random_word());
      send_beat(1'b0, 32'h0000_0000, 64'h8000_0000_0000_0001);
      send_beat(1'b1, 32'h0000_0000, '1);
   endtask

   // Fills one port past its depth, then drains it past empty.
   task automatic test_port_overflow();
      logic [mbx_pkg::KEY_W-1:0] id;
      id = $urandom;
      repeat (STACK_DEPTH + 2) send_beat(1'b0, id, random_word());
      repeat (STACK_DEPTH + 1) send_beat(1'b1, id, random_word());
   endtask

   // Claims fresh identifiers to fill the table, then two more pushes and three pops.
   task automatic test_table_overflow();
      while (slots_used < NUM_PORTS) send_beat(1'b0, $urandom, random_word());
      send_beat(1'b0, $urandom, random_word());
      send_beat(1'b0, 32'hFFFF_FFFE, random_word());
      send_beat(1'b1, $urandom, random_word());
      send_beat(1'b1, slot_key[NUM_PORTS - 1], random_word());
      send_beat(1'b1, slot_key[NUM_PORTS - 1], random_word());
   endtask

   // Short mixed or push runs and long push or pop runs on one port at a time, so that
   // stacks regularly reach both full and empty.
   task automatic test_random_traffic(input int n_items);
      int                        sent;
      int                        len;
      int                        mode;
      int                        k;
      logic                      op;
      logic [mbx_pkg::KEY_W-1:0] id;
      sent = 0;
      while (sent < n_items) begin
         id   = pick_port_key();
         mode = $urandom_range(0, 9);
         len  = (mode < 6) ? $urandom_range(1, 8) : $urandom_range(20, 36);
         for (k = 0; k < len && sent < n_items; k++) begin
            if (mode < 4) op = 1'($urandom_range(0, 1));
            else          op = (mode >= 8);
            send_beat(op, id, random_word());
            sent++;
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_kind     = 1'b0;
      req_port_id  = '0;
      req_payload  = '0;
      error_count  = 0;
      cycle_count  = 0;
      slots_used   = 0;
      gaps_enabled = 1'b1;
      foreach (depth_of[i]) depth_of[i] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_port_overflow();
      test_random_traffic(700);
      gaps_enabled = 1'b0;
      test_random_traffic(450);
      gaps_enabled = 1'b1;
      test_table_overflow();
      test_random_traffic(550);

      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (2 * NUM_PORTS) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
